[rtl/core/wcmmr_pkg.sv]
`timescale 1ns / 1ps

package wcmmr_pkg;

  // Sample format and element size.
  localparam int SAMPLE_BITS = 16;
  localparam int COLUMNS     = 256;

  // Column numbering: the index port carries the low eight bits, the status
  // record carries all nine bits of the count of complete columns in the element.
  localparam int COL_W   = 9;
  localparam int IDX_W   = 8;
  localparam int SPC_W   = 16;

  // Accumulator widths: a count of up to 65535 samples, each square below 2^31.
  localparam int CNT_W   = 17;
  localparam int MAG_W   = SAMPLE_BITS;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = 47;

  // Divide and square-root unit.
  localparam int QUO_W      = 32;
  localparam int ROOT_W     = 16;
  localparam int REM_W      = 17;
  localparam int ALU_W      = REM_W + 2;
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W     = 6;

  // Stream word widths.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 72;

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Input kind codes.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_END    = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[rtl/core/wcmmr_root_unit.sv]
`timescale 1ns / 1ps

// Restoring long division of the square sum by the sample count, followed by a
// digit-by-digit square root of the quotient. Both passes share one subtractor.
module wcmmr_root_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [wcmmr_pkg::SUM_W-1:0]       dividend_i,
  input  logic [wcmmr_pkg::CNT_W-1:0]       divisor_i,
  output wcmmr_pkg::unit_stat_t             stat_o,
  output logic [wcmmr_pkg::ROOT_W-1:0]      root_o
);

  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_DIV  = 3'b010,
    U_SQRT = 3'b100
  } ustate_e;

  ustate_e                            state_q, state_d;
  logic [wcmmr_pkg::SUM_W-1:0]        dvd_q, dvd_d;
  logic [wcmmr_pkg::CNT_W-1:0]        dsr_q, dsr_d;
  logic [wcmmr_pkg::QUO_W-1:0]        qr_q, qr_d;
  logic [wcmmr_pkg::REM_W-1:0]        rem_q, rem_d;
  logic [wcmmr_pkg::ROOT_W-1:0]       root_q, root_d;
  logic [wcmmr_pkg::STEP_W-1:0]       cnt_q, cnt_d;
  logic                               done_q, done_d;

  logic [wcmmr_pkg::ALU_W-1:0]        alu_a, alu_b, alu_diff;
  logic                               alu_ge;
  logic [wcmmr_pkg::REM_W-1:0]        rem_next;

  // Shared subtractor: operands depend on which pass is running.
  always_comb begin
    unique case (state_q)
      U_DIV: begin
        alu_a = {1'b0, rem_q, dvd_q[wcmmr_pkg::SUM_W-1]};
        alu_b = {2'b00, dsr_q};
      end
      U_SQRT: begin
        alu_a = {rem_q, qr_q[wcmmr_pkg::QUO_W-1 -: 2]};
        alu_b = {1'b0, root_q, 2'b01};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_ge   = (alu_a >= alu_b);
  assign alu_diff = alu_a - alu_b;
  assign rem_next = alu_ge ? alu_diff[wcmmr_pkg::REM_W-1:0] : alu_a[wcmmr_pkg::REM_W-1:0];

  always_comb begin
    state_d = state_q;
    dvd_d   = dvd_q;
    dsr_d   = dsr_q;
    qr_d    = qr_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      U_IDLE: begin
        if (start_i) begin
          dvd_d   = dividend_i;
          dsr_d   = divisor_i;
          qr_d    = '0;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = U_DIV;
        end
      end
      U_DIV: begin
        dvd_d = {dvd_q[wcmmr_pkg::SUM_W-2:0], 1'b0};
        rem_d = rem_next;
        qr_d  = {qr_q[wcmmr_pkg::QUO_W-2:0], alu_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == wcmmr_pkg::STEP_W'(wcmmr_pkg::DIV_STEPS - 1)) begin
          // Quotient is complete; it becomes the radicand.
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = U_SQRT;
        end
      end
      U_SQRT: begin
        qr_d   = {qr_q[wcmmr_pkg::QUO_W-3:0], 2'b00};
        rem_d  = rem_next;
        root_d = {root_q[wcmmr_pkg::ROOT_W-2:0], alu_ge};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == wcmmr_pkg::STEP_W'(wcmmr_pkg::SQRT_STEPS - 1)) begin
          done_d  = 1'b1;
          state_d = U_IDLE;
        end
      end
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    dsr_q  <= dsr_d;
    qr_q   <= qr_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign stat_o.busy = (state_q != U_IDLE);
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

[rtl/core/waveform_column_min_max_rms_unit.sv]
`timescale 1ns / 1ps

// Waveform column summariser. Audio samples arrive on the slave stream, one
// signed 16-bit sample per word, with tuser low; a word with tuser high marks
// the end of available data. Every samples_per_column samples make one display
// column, and a column word on the master stream carries its index within the
// element, its minimum, maximum and floor RMS; tlast flags the last column of
// an element of 256 columns. An end-of-data word drops the partial column and
// yields a status word (tuser high) with the count of complete columns in the element.
// A sample that does not close a column is squared and accumulated. A sample
// that closes one is squared and accumulated, then the square sum is divided
// bit-serially by the count and the square root of the quotient is taken, both
// on one shared subtractor; the root is then handed over and loaded into the
// output register. The result waits in that output register, so the next input
// word is taken while the receiver stalls; only a further result stalls until
// that register is free. Reset clears the accumulators, the column count and
// the output valid, and sets the column length to 256. The column length
// register is written with cfg_wr_en_i; the user must write it only while the
// block is idle, as the block itself does not enforce this.
module waveform_column_min_max_rms_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_wr_en_i,
  input  logic [wcmmr_pkg::SPC_W-1:0]          cfg_wr_data_i,   // samples_per_column
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [wcmmr_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,  // [15:0] sample
  input  logic                                 s_axis_tuser_i,  // [0] kind
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [7:0] column_index, [23:8] col_min, [39:24] col_max, [55:40] col_rms,
  // [64:56] available_columns, [71:65] zero
  output logic [wcmmr_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  output logic                                 m_axis_tuser_o,  // [0] is_status
  output logic                                 m_axis_tlast_o   // element_full
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQR  = 5'b00010,
    S_ACC  = 5'b00100,
    S_CALC = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e                                  state_q, state_d;
  logic [wcmmr_pkg::SPC_W-1:0]             spc_q;
  logic signed [wcmmr_pkg::SAMPLE_BITS-1:0] sample_q, sample_d;
  logic                                    is_stat_q, is_stat_d;
  logic [wcmmr_pkg::SQ_W-1:0]              sq_q, sq_d;
  logic signed [wcmmr_pkg::SAMPLE_BITS-1:0] min_q, min_d, max_q, max_d;
  logic [wcmmr_pkg::SUM_W-1:0]             sum_q, sum_d;
  logic [wcmmr_pkg::CNT_W-1:0]             cnt_q, cnt_d;
  logic [wcmmr_pkg::COL_W-1:0]             col_q, col_d;

  logic                                    out_valid_q, out_valid_d;
  logic [wcmmr_pkg::OUT_DATA_W-1:0]        out_data_q, out_data_d;
  logic                                    out_user_q, out_user_d;
  logic                                    out_last_q, out_last_d;

  logic [wcmmr_pkg::MAG_W-1:0]             mag;
  logic [wcmmr_pkg::CNT_W-1:0]             spc_eff;
  logic                                    col_done;
  logic                                    elem_full;
  logic                                    in_fire;
  logic                                    slot_free;
  logic                                    unit_start;
  wcmmr_pkg::unit_stat_t                   unit_stat;
  logic [wcmmr_pkg::ROOT_W-1:0]            root;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !out_valid_q || m_axis_tready_i;

  // Magnitude of the held sample; the most negative value maps to 2^15.
  assign mag = sample_q[wcmmr_pkg::SAMPLE_BITS-1] ?
               wcmmr_pkg::MAG_W'(~sample_q + 1'b1) : wcmmr_pkg::MAG_W'(sample_q);

  // A zero column length behaves as one.
  assign spc_eff   = (spc_q == '0) ? wcmmr_pkg::CNT_W'(1) : {1'b0, spc_q};
  assign col_done  = (cnt_q >= spc_eff);
  assign elem_full = (col_q >= wcmmr_pkg::COL_W'(wcmmr_pkg::COLUMNS - 1));

  always_comb begin
    state_d     = state_q;
    sample_d    = sample_q;
    is_stat_d   = is_stat_q;
    sq_d        = sq_q;
    min_d       = min_q;
    max_d       = max_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    col_d       = col_q;
    unit_start  = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          sample_d  = s_axis_tdata_i[wcmmr_pkg::SAMPLE_BITS-1:0];
          is_stat_d = (s_axis_tuser_i == wcmmr_pkg::KIND_END);
          state_d   = (s_axis_tuser_i == wcmmr_pkg::KIND_END) ? S_EMIT : S_SQR;
        end
      end
      S_SQR: begin
        sq_d = mag * mag;
        if (sample_q < min_q) begin
          min_d = sample_q;
        end
        if (sample_q > max_q) begin
          max_d = sample_q;
        end
        cnt_d   = cnt_q + 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        sum_d = sum_q + wcmmr_pkg::SUM_W'(sq_q);
        if (col_done) begin
          unit_start = 1'b1;
          state_d    = S_CALC;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CALC: begin
        if (unit_stat.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_user_d  = is_stat_q;
          if (is_stat_q) begin
            out_data_d = '0;
            out_data_d[64:56] = col_q;
            out_last_d = 1'b0;
            col_d      = '0;
          end else begin
            out_data_d = '0;
            out_data_d[7:0]   = col_q[wcmmr_pkg::IDX_W-1:0];
            out_data_d[23:8]  = min_q;
            out_data_d[39:24] = max_q;
            out_data_d[55:40] = root;
            out_last_d = elem_full;
            col_d      = elem_full ? '0 : col_q + 1'b1;
          end
          // Start a fresh column.
          min_d   = wcmmr_pkg::SMAX;
          max_d   = wcmmr_pkg::SMIN;
          sum_d   = '0;
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  wcmmr_root_unit u_root (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (unit_start),
    .dividend_i (sum_d),
    .divisor_i  (cnt_q),
    .stat_o     (unit_stat),
    .root_o     (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      spc_q       <= wcmmr_pkg::SPC_W'(256);
      min_q       <= wcmmr_pkg::SMAX;
      max_q       <= wcmmr_pkg::SMIN;
      sum_q       <= '0;
      cnt_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_wr_en_i) begin
        spc_q <= cfg_wr_data_i;
      end
      min_q       <= min_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    is_stat_q  <= is_stat_d;
    sq_q       <= sq_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

  // The root unit only finishes while the sequencer is waiting for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_stat.done |-> (state_q == S_CALC))
    else $error("root unit finished outside the calculation state");

  // No new word is taken while the shared unit is still working.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !unit_stat.busy)
    else $error("input ready while the root unit is busy");

  // A status word carries only the column count; a column word carries none.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o ? (m_axis_tdata_o[55:0] == '0 && !m_axis_tlast_o)
                                        : (m_axis_tdata_o[64:56] == '0)))
    else $error("output word has fields set that its kind does not use");

endmodule
